// ===== hdl/tarc_pkg.sv =====
// Shared types and constants for the tremor actuator ramp controller.
// No dependencies; imported by tremor_actuator_ramp_controller_top.
package tarc_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FLAGS_W = 3;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [FLAGS_W-1:0]     flags_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DUTY_MAX   = 2'd0,
    CFG_DUTY_MIN   = 2'd1,
    CFG_HOLD_LIMIT = 2'd2,
    CFG_RAMP_DIV   = 2'd3
  } cfg_reg_t;

  // Item kinds
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam flags_t FULL_DETECT = 3'b111;
  localparam word_t  HOLD_MAX    = 16'hFFFF;

  // Reset values
  localparam word_t DUTY_MAX_RST   = 16'd1030;
  localparam word_t DUTY_MIN_RST   = 16'd980;
  localparam word_t HOLD_LIMIT_RST = 16'd15000;
  localparam word_t RAMP_DIV_RST   = 16'd10;

  // One result beat
  typedef struct packed {
    logic  actuator_on;
    word_t duty;
    word_t hold_count;
  } result_t;

endpackage

// ===== hdl/tremor_actuator_ramp_controller_top.sv =====
// Tremor actuator ramp controller: on/off decision, hold timer and PWM duty ramp.
// Depends on tarc_pkg (types, register map, reset constants).
//
// Usage:
//   Item channel (item_valid / item_stall): each beat is either a button
//   sample (opcode OP_BUTTON, button_level) or a control tick (opcode OP_TICK,
//   tremor_flags). A button sample produces no result; a rising edge of the
//   button level arms a toggle request for the next tick.
//   Result channel (result_valid / result_stall): one beat per tick carrying
//   actuator_on, duty and hold_count as they stand after that tick.
//   Config channel (cfg_valid / cfg_ready): cfg_index selects duty_max,
//   duty_min, hold_limit or ramp_div; cfg_ready is always high. Write only
//   while no tick is in flight.
// Timing:
//   A tick's result goes to the output register, or to the skid entry if the
//   receiver stalls. One item per cycle while item_stall is low; state updates
//   in a single registered pass, so back-to-back ticks see each other's results.
// Stall behavior:
//   The output register is backed by a one-entry skid register. While the
//   receiver stalls, one more result can be absorbed; item_stall rises only
//   once the skid entry is occupied, and drops as soon as it drains.
// Reset (rst, synchronous, active high): config returns to its defaults,
//   actuator off, counters zero, duty 980, button seen as high, no toggle.
module tremor_actuator_ramp_controller_top (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 opcode,
  input  logic                 button_level,
  input  tarc_pkg::flags_t     tremor_flags,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 actuator_on,
  output tarc_pkg::word_t      duty,
  output tarc_pkg::word_t      hold_count,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tarc_pkg::cfg_index_t cfg_index,
  input  tarc_pkg::word_t      cfg_data
);
  import tarc_pkg::*;

  // Config registers
  word_t duty_max, duty_min, hold_limit, ramp_div;

  // Control state
  logic  on_state;
  word_t hold_counter;
  word_t ramp_counter;
  word_t duty_value;
  logic  button_previous;
  logic  toggle_pending;

  // Next values for one tick
  logic  on_state_next;
  word_t hold_counter_next;
  word_t ramp_counter_next;
  word_t duty_value_next;
  word_t ramp_inc;
  logic  full;
  logic  ramp_step;

  // Output stage and skid entry
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  result_t res_new;

  logic item_accept;
  logic tick_accept;
  logic button_accept;
  logic out_free;

  assign cfg_ready     = 1'b1;
  assign item_stall    = skid_valid;
  assign item_accept   = item_valid && !item_stall;
  assign tick_accept   = item_accept && (opcode == OP_TICK);
  assign button_accept = item_accept && (opcode == OP_BUTTON);
  assign out_free      = !result_valid || !result_stall;

  assign actuator_on = out_reg.actuator_on;
  assign duty        = out_reg.duty;
  assign hold_count  = out_reg.hold_count;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_max   <= DUTY_MAX_RST;
      duty_min   <= DUTY_MIN_RST;
      hold_limit <= HOLD_LIMIT_RST;
      ramp_div   <= RAMP_DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DUTY_MAX:   duty_max   <= cfg_data;
        CFG_DUTY_MIN:   duty_min   <= cfg_data;
        CFG_HOLD_LIMIT: hold_limit <= cfg_data;
        CFG_RAMP_DIV:   ramp_div   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Tick update: on/off decision uses the hold count from before the tick.
  always_comb begin
    full = (tremor_flags & FULL_DETECT) == FULL_DETECT;

    if (full || (toggle_pending && !on_state)) begin
      on_state_next = 1'b1;
    end else if ((hold_counter >= hold_limit) || (toggle_pending && on_state)) begin
      on_state_next = 1'b0;
    end else begin
      on_state_next = on_state;
    end

    if (on_state_next && !full) begin
      hold_counter_next = (hold_counter == HOLD_MAX) ? hold_counter
                                                     : hold_counter + 16'd1;
    end else begin
      hold_counter_next = '0;
    end

    // Divider of zero falls out naturally: the counter wraps before matching.
    ramp_inc  = ramp_counter + 16'd1;
    ramp_step = (ramp_inc == ramp_div);

    duty_value_next   = duty_value;
    ramp_counter_next = ramp_inc;
    if (ramp_step) begin
      ramp_counter_next = '0;
      if (on_state_next && (duty_value < duty_max)) begin
        duty_value_next = duty_value + 16'd1;
      end else if (!on_state_next && (duty_value > duty_min)) begin
        duty_value_next = duty_value - 16'd1;
      end
    end

    res_new.actuator_on = on_state_next;
    res_new.duty        = duty_value_next;
    res_new.hold_count  = hold_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_state        <= 1'b0;
      hold_counter    <= '0;
      ramp_counter    <= '0;
      duty_value      <= DUTY_MIN_RST;
      button_previous <= 1'b1;
      toggle_pending  <= 1'b0;
    end else if (tick_accept) begin
      on_state       <= on_state_next;
      hold_counter   <= hold_counter_next;
      ramp_counter   <= ramp_counter_next;
      duty_value     <= duty_value_next;
      toggle_pending <= 1'b0;
    end else if (button_accept) begin
      if (button_level && !button_previous) begin
        toggle_pending <= 1'b1;
      end
      button_previous <= button_level;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (tick_accept) begin
      if (out_free) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_reg <= skid_reg;
      end
    end else if (tick_accept) begin
      if (out_free) begin
        out_reg <= res_new;
      end else begin
        skid_reg <= res_new;
      end
    end
  end

`ifndef ASSERT_OFF
  // Skid entry is only ever filled behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry valid without output beat");

  // A tick taken with free output appears at the output next cycle.
  a_tick_to_out: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && out_free) |=> (result_valid && (out_reg == $past(res_new))))
    else $error("tick result not presented");

  // Hold time only accumulates while the actuator is on.
  a_hold_only_on: assert property (@(posedge clk) disable iff (rst)
    !on_state |-> (hold_counter == '0))
    else $error("hold counter running while off");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for tremor_actuator_ramp_controller_top: directed and random item streams,
// each tick checked beat by beat against an in-bench model of the on/off, hold and duty logic.
// Depends on tarc_pkg and the RTL top level only.
module testbench;
  import tarc_pkg::*;

  localparam int CYCLE_LIMIT   = 20_000;
  localparam int GAP_PCT       = 7;   // idle / stall rate per side, in percent
  localparam int SETTLE_CYCLES = 4;   // extra wait after the last owed beat, for button beats

  // DUT ports; all inputs are known from time zero
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic       opcode       = OP_BUTTON;
  logic       button_level = 1'b0;
  flags_t     tremor_flags = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       actuator_on;
  word_t      duty;
  word_t      hold_count;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index    = CFG_DUTY_MAX;
  word_t      cfg_data     = '0;

  tremor_actuator_ramp_controller_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .button_level (button_level),
    .tremor_flags (tremor_flags),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .actuator_on  (actuator_on),
    .duty         (duty),
    .hold_count   (hold_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Mirror of the block's registers: config copy plus controller state.
  word_t lim_duty_max = DUTY_MAX_RST;
  word_t lim_duty_min = DUTY_MIN_RST;
  word_t lim_hold     = HOLD_LIMIT_RST;
  word_t lim_ramp     = RAMP_DIV_RST;
  logic  act_on       = 1'b0;
  word_t hold_ticks   = '0;
  word_t ramp_ticks   = '0;
  word_t pwm_duty     = DUTY_MIN_RST;
  logic  btn_prev     = 1'b1;   // button counts as high out of reset
  logic  toggle_armed = 1'b0;

  result_t pending_status[$];   // status beats owed by the DUT, oldest first
  result_t due;
  int      errors   = 0;
  int      cycles   = 0;
  int      hold_off = 0;        // receiver hold-off, in cycles
  bit      quiet    = 1'b0;     // suppresses random idling on both sides

  // One control tick. Order matters: on/off decision uses the hold count from
  // before this tick, then ramp count, hold count, duty step, toggle clear.
  function automatic result_t step_actuator(input flags_t flags);
    logic    full;
    result_t r;
    full = (flags == FULL_DETECT);
    if (full || (toggle_armed && !act_on))
      act_on = 1'b1;
    else if (hold_ticks >= lim_hold || (toggle_armed && act_on))
      act_on = 1'b0;
    ramp_ticks = ramp_ticks + 16'd1;   // wraps at 16 bits, as the divider-zero case needs
    if (act_on && !full) begin
      if (hold_ticks != HOLD_MAX)
        hold_ticks = hold_ticks + 16'd1;
    end else begin
      hold_ticks = '0;
    end
    if (ramp_ticks == lim_ramp) begin
      // only ever moves toward the active limit, never away
      if (act_on && pwm_duty < lim_duty_max)
        pwm_duty = pwm_duty + 16'd1;
      else if (!act_on && pwm_duty > lim_duty_min)
        pwm_duty = pwm_duty - 16'd1;
      ramp_ticks = '0;
    end
    toggle_armed = 1'b0;
    r.actuator_on = act_on;
    r.duty        = pwm_duty;
    r.hold_count  = hold_ticks;
    return r;
  endfunction

  // Button sample: rising edge arms a toggle for the next tick.
  function automatic void note_button(input logic level);
    if (level && !btn_prev)
      toggle_armed = 1'b1;
    btn_prev = level;
  endfunction

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < GAP_PCT);
  endfunction

  // Offer one item beat; inputs move on the falling edge, acceptance is seen
  // at the rising edge. Valid stays high into the next call unless a gap is drawn.
  task automatic send_beat(input logic op, input logic level, input flags_t flags);
    @(negedge clk);
    while (take_gap()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    opcode       <= op;
    button_level <= level;
    tremor_flags <= flags;
    do @(posedge clk); while (item_stall);
    if (op == OP_TICK)
      pending_status.push_back(step_actuator(flags));
    else
      note_button(level);
  endtask

  // Unused payload fields carry random values so every input bit toggles.
  task automatic send_tick(input flags_t flags);
    send_beat(OP_TICK, 1'($urandom), flags);
  endtask

  task automatic send_button(input logic level);
    send_beat(OP_BUTTON, level, 3'($urandom));
  endtask

  task automatic press_button();
    send_button(1'b0);
    send_button(1'b1);
  endtask

  // Drop valid, wait for every owed beat, then let button beats finish too.
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called once the block has settled.
  task automatic write_reg(input cfg_reg_t idx, input word_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DUTY_MAX:   lim_duty_max = value;
      CFG_DUTY_MIN:   lim_duty_min = value;
      CFG_HOLD_LIMIT: lim_hold     = value;
      CFG_RAMP_DIV:   lim_ramp     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random duty limit: the extremes now and then, otherwise near the current
  // duty so the ramp actually reaches it within a phase.
  function automatic word_t pick_duty();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return HOLD_MAX;
      default: return word_t'(pwm_duty + $urandom_range(0, 40) - 20);
    endcase
  endfunction

  // Receiver side: a counted hold-off when a test asks for one, random
  // stalls otherwise. Driven on the falling edge like every other input.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      result_stall <= 1'b1;
      hold_off--;
    end else begin
      result_stall <= take_gap();
    end
  end

  // Result checker: every accepted beat against the oldest owed status.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: on %0b duty %0d hold %0d",
                 $time, actuator_on, duty, hold_count);
      end else begin
        due = pending_status.pop_front();
        if (actuator_on !== due.actuator_on) begin
          errors++;
          $display("%0t: actuator_on expected %0b got %0b",
                   $time, due.actuator_on, actuator_on);
        end
        if (duty !== due.duty) begin
          errors++;
          $display("%0t: duty expected %0d got %0d", $time, due.duty, duty);
        end
        if (hold_count !== due.hold_count) begin
          errors++;
          $display("%0t: hold_count expected %0d got %0d",
                   $time, due.hold_count, hold_count);
        end
      end
    end
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tremor_actuator_ramp_controller_top verification failed");
      $finish;
    end
  end

  // Default config: every flag pattern, toggles both ways, edge detection.
  task automatic test_directed();
    send_tick(3'b000);
    send_button(1'b1);           // already high after reset: no edge
    press_button();              // low then high arms a toggle
    send_tick(3'b010);           // toggle while off turns it on
    send_tick(3'b101);
    send_tick(3'b100);
    send_tick(3'b001);
    send_tick(3'b011);
    send_tick(3'b110);
    send_tick(FULL_DETECT);      // full detection clears the hold count
    press_button();
    send_tick(FULL_DETECT);      // full detection wins over a pending toggle
    press_button();
    send_tick(3'b000);           // toggle while on turns it off
    send_button(1'b1);           // held high, no new edge
    repeat (4) send_tick(3'b000);
    press_button();
    send_button(1'b0);           // release does not cancel the armed toggle
    send_tick(3'b001);
  endtask

  // Corner settings: zero hold limit, min above max, duty outside limits,
  // and the register extremes.
  task automatic test_limit_cases();
    word_t base;
    settle();
    write_reg(CFG_RAMP_DIV, 16'd1);
    write_reg(CFG_HOLD_LIMIT, 16'd0);
    write_reg(CFG_DUTY_MAX, HOLD_MAX);
    write_reg(CFG_DUTY_MIN, 16'd0);
    send_tick(FULL_DETECT);
    send_tick(3'b011);           // zero limit: off on first tick without full detect
    press_button();
    send_tick(3'b000);           // toggle still turns it on with a zero limit
    send_tick(3'b000);
    settle();
    // min above max: rises only to max while on, never falls while off
    base = pwm_duty;
    write_reg(CFG_DUTY_MAX, word_t'(base + 3));
    write_reg(CFG_DUTY_MIN, word_t'(base + 6));
    write_reg(CFG_HOLD_LIMIT, 16'd3);
    repeat (6) send_tick(FULL_DETECT);
    repeat (6) send_tick(3'b000);
    settle();
    // duty now above max: on must not push it further; off steps down to min
    write_reg(CFG_DUTY_MAX, base);
    write_reg(CFG_DUTY_MIN, base);
    repeat (3) send_tick(FULL_DETECT);
    repeat (8) send_tick(3'b100);
    settle();
    write_reg(CFG_DUTY_MAX, 16'd0);
    write_reg(CFG_DUTY_MIN, HOLD_MAX);
    write_reg(CFG_RAMP_DIV, HOLD_MAX);
    repeat (4) send_tick(flags_t'($urandom_range(0, 7)));
  endtask

  // Long runs: hold count climbing under a high limit, a divider lowered
  // below the running count, and a zero divider waiting for the wrap.
  task automatic test_long_counters();
    settle();
    write_reg(CFG_RAMP_DIV, 16'd100);
    write_reg(CFG_HOLD_LIMIT, HOLD_MAX);
    write_reg(CFG_DUTY_MAX, HOLD_MAX);
    write_reg(CFG_DUTY_MIN, 16'd0);
    repeat (51) send_tick(FULL_DETECT);
    settle();
    write_reg(CFG_RAMP_DIV, 16'd20);
    repeat (40) send_tick(flags_t'($urandom_range(0, 6)));
    settle();
    write_reg(CFG_RAMP_DIV, 16'd0);
    repeat (30) send_tick(flags_t'($urandom_range(0, 6)));
  endtask

  // Receiver holds off long enough for the skid entry to fill and the
  // item side to stall, while ticks keep coming back to back.
  task automatic test_backpressure();
    settle();
    write_reg(CFG_RAMP_DIV, 16'd2);
    quiet    = 1'b1;
    hold_off = 60;
    repeat (40) send_tick(3'($urandom));
    settle();
    quiet = 1'b0;
  endtask

  // Random phases with fresh settings each; one phase runs without idling.
  task automatic test_random();
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      quiet = (phase == 3);
      write_reg(CFG_DUTY_MAX, pick_duty());
      write_reg(CFG_DUTY_MIN, pick_duty());
      write_reg(CFG_HOLD_LIMIT, ($urandom_range(0, 9) == 0) ?
                word_t'($urandom_range(0, 1) ? HOLD_MAX : 16'd0) :
                word_t'($urandom_range(0, 30)));
      write_reg(CFG_RAMP_DIV, ($urandom_range(0, 9) == 0) ?
                word_t'($urandom_range(0, 1) ? HOLD_MAX : 16'd0) :
                word_t'($urandom_range(1, 4)));
      for (int n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          press_button();
          n++;
        end else if (pick < 22) begin
          send_button(1'($urandom));
        end else begin
          send_tick(($urandom_range(0, 99) < 30) ? FULL_DETECT :
                    flags_t'($urandom_range(0, 7)));
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_limit_cases();
    test_long_counters();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0 && pending_status.size() == 0)
      $display("tremor_actuator_ramp_controller_top verification clean");
    else
      $display("tremor_actuator_ramp_controller_top verification failed");
    $finish;
  end

endmodule
